>>> rtl/core/slip_rdc_pkg.sv
package slip_rdc_pkg;

  // Default largest frame the deframer keeps
  localparam int unsigned MAX_FRAME_DEF = 64;

  // SLIP special bytes
  localparam logic [7:0] END_BYTE     = 8'hC0;
  localparam logic [7:0] ESC_BYTE     = 8'hDB;
  localparam logic [7:0] ESC_END_BYTE = 8'hDC;
  localparam logic [7:0] ESC_ESC_BYTE = 8'hDD;

  // Direction byte that marks a reply
  localparam logic [7:0] REPLY_DIR = 8'h01;

  // Configuration register indexes
  localparam int unsigned  CFG_IDX_W    = 2;
  localparam logic [1:0]   CFG_CAPACITY = 2'd0;
  localparam logic [1:0]   CFG_COMMAND  = 2'd1;
  localparam logic [1:0]   CFG_MIN_LEN  = 2'd2;

  // Configuration register reset values
  localparam logic [6:0] CAPACITY_RST = 7'd64;
  localparam logic [7:0] COMMAND_RST  = 8'd8;
  localparam logic [6:0] MIN_LEN_RST  = 7'd10;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [6:0] capacity;
    logic [7:0] command;
    logic [6:0] min_len;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [5:0] index;
    logic [6:0] length;
    logic       is_reply;
    logic       success;
    logic [7:0] reason;
  } result_t;

endpackage

>>> rtl/core/slip_reply_deframer_checker.sv
// SLIP reply deframer and checker.
// A result word passes through the input register, then is decoded into the result register;
// the decode waits while a result word is still held in the result register.
// Throughput: one input word per cycle; a waiting result does not stall input
// until the input register is also held.
// Reset (rst_ni low, async): config to defaults, framing state cleared, no word held.
module slip_reply_deframer_checker import slip_rdc_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // byte input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 result_kind_o,
  output logic [7:0]           data_byte_o,
  output logic [5:0]           byte_index_o,
  output logic [6:0]           frame_length_o,
  output logic                 is_reply_o,
  output logic                 success_o,
  output logic [7:0]           reason_code_o
);

  cfg_t    cfg;
  logic    in_valid_q;
  logic    [7:0] byte_q;
  logic    out_valid_q;
  result_t res_q;
  logic    out_free;
  logic    process;
  logic    res_valid;
  result_t res;

  assign cfg_ready_o = 1'b1;

  slip_rdc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // pipeline flow control
  assign out_free   = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || process;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  slip_rdc_decode #(
    .MaxFrame(MAX_FRAME)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (process),
    .byte_i     (byte_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= process && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = res_q.kind;
  assign data_byte_o    = res_q.data;
  assign byte_index_o   = res_q.index;
  assign frame_length_o = res_q.length;
  assign is_reply_o     = res_q.is_reply;
  assign success_o      = res_q.success;
  assign reason_code_o  = res_q.reason;

endmodule

>>> rtl/core/slip_rdc_cfg.sv
module slip_rdc_cfg import slip_rdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAPACITY: cfg_d.capacity = cfg_data_i[6:0];
        CFG_COMMAND:  cfg_d.command  = cfg_data_i;
        CFG_MIN_LEN:  cfg_d.min_len  = cfg_data_i[6:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity <= CAPACITY_RST;
      cfg_q.command  <= COMMAND_RST;
      cfg_q.min_len  <= MIN_LEN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/slip_rdc_decode.sv
module slip_rdc_decode import slip_rdc_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam int unsigned CmpW = (CntW > 7) ? CntW : 7;

  logic            open_q, open_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [7:0]      penult_q, penult_d;
  logic [7:0]      final_q, final_d;

  logic [CmpW-1:0] count_ext;
  logic [CmpW-1:0] cap_raw;
  logic [CmpW-1:0] cap_eff;
  logic [CmpW-1:0] min_ext;
  logic            room;
  logic            two_plus;
  logic [7:0]      dec_byte;

  // widened views for compares
  assign count_ext = CmpW'(count_q);
  assign cap_raw   = CmpW'(cfg_i.capacity);
  assign cap_eff   = (cap_raw > CmpW'(MaxFrame)) ? CmpW'(MaxFrame) : cap_raw;
  assign min_ext   = CmpW'(cfg_i.min_len);
  assign room      = count_ext < cap_eff;
  assign two_plus  = count_ext >= CmpW'(2);

  // decoded byte: unescape only the second byte of an escape pair
  always_comb begin
    priority if (esc_q && (byte_i == ESC_END_BYTE)) dec_byte = END_BYTE;
    else if (esc_q && (byte_i == ESC_ESC_BYTE))     dec_byte = ESC_BYTE;
    else                                            dec_byte = byte_i;
  end

  // framing state machine and result build
  always_comb begin
    open_d      = open_q;
    esc_d       = esc_q;
    count_d     = count_q;
    first_d     = first_q;
    second_d    = second_q;
    penult_d    = penult_q;
    final_d     = final_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (en_i) begin
      priority if (byte_i == END_BYTE) begin
        esc_d = 1'b0;
        priority if (!open_q) begin
          open_d  = 1'b1;
          count_d = '0;
        end else if (count_q != '0) begin
          // close the frame and summarize it
          res_valid_o    = 1'b1;
          res_o.kind     = KIND_SUMMARY;
          res_o.length   = count_ext[6:0];
          res_o.is_reply = two_plus && (count_ext >= min_ext) &&
                           (first_q == REPLY_DIR) && (second_q == cfg_i.command);
          res_o.success  = two_plus && (penult_q == 8'h00);
          res_o.reason   = final_q;
          open_d         = 1'b0;
          count_d        = '0;
        end else begin
          // empty frame: stay open
          open_d = open_q;
        end
      end else if (!open_q) begin
        // noise before an opening END
        open_d = open_q;
      end else if (!esc_q && (byte_i == ESC_BYTE)) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (room) begin
          if (count_q == '0) first_d = dec_byte;
          if (count_q == CntW'(1)) second_d = dec_byte;
          penult_d    = final_q;
          final_d     = dec_byte;
          count_d     = count_q + CntW'(1);
          res_valid_o = 1'b1;
          res_o.kind  = KIND_DATA;
          res_o.data  = esc_q ? dec_byte : byte_i;
          res_o.index = count_ext[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      esc_q    <= 1'b0;
      count_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      penult_q <= '0;
      final_q  <= '0;
    end else begin
      open_q   <= open_d;
      esc_q    <= esc_d;
      count_q  <= count_d;
      first_q  <= first_d;
      second_q <= second_d;
      penult_q <= penult_d;
      final_q  <= final_d;
    end
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  import slip_rdc_pkg::*;

  // Register index with no register behind it; writes are dropped
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_BYTES = 170;
  localparam int unsigned EMPTY_PHASE_BYTES = 60;

  // Decoder state and expected words, tracked alongside the block
  class reply_frame_tracker;
    logic [6:0]  capacity;
    logic [7:0]  command;
    logic [6:0]  min_len;
    bit          open;
    bit          esc_pend;
    int unsigned count;
    logic [7:0]  first_b;
    logic [7:0]  second_b;
    logic [7:0]  penult_b;
    logic [7:0]  last_b;
    result_t     expected_words[$];
    int unsigned fails;
    int unsigned seen;
    int unsigned n_data;
    int unsigned n_summary;
    int unsigned n_reply;
    int unsigned n_success;

    function new();
      capacity  = CAPACITY_RST;
      command   = COMMAND_RST;
      min_len   = MIN_LEN_RST;
      open      = 1'b0;
      fails     = 0;
      seen      = 0;
      n_data    = 0;
      n_summary = 0;
      n_reply   = 0;
      n_success = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      esc_pend = 1'b0;
      count    = 0;
      first_b  = 8'h00;
      second_b = 8'h00;
      penult_b = 8'h00;
      last_b   = 8'h00;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_CAPACITY: capacity = val[6:0];
        CFG_COMMAND:  command  = val;
        CFG_MIN_LEN:  min_len  = val[6:0];
        default: ;
      endcase
    endfunction

    // Work out what one accepted raw byte produces, if anything
    function void note_byte(logic [7:0] raw);
      result_t     r;
      logic [7:0]  c;
      int unsigned cap;
      c = raw;
      r = '0;
      if (c == END_BYTE) begin
        esc_pend = 1'b0;
        if (!open) begin
          open = 1'b1;
          clear_frame();
          return;
        end
        // empty frame: delimiter only, frame stays open
        if (count == 0) return;
        r.kind     = KIND_SUMMARY;
        r.length   = count[6:0];
        r.is_reply = count >= 2 && count >= 32'(min_len) && first_b == REPLY_DIR &&
                     second_b == command;
        r.success  = count >= 2 && penult_b == 8'h00;
        r.reason   = last_b;
        expected_words.push_back(r);
        open = 1'b0;
        clear_frame();
        return;
      end
      if (!open) return;
      if (esc_pend) begin
        if (c == ESC_END_BYTE) c = END_BYTE;
        else if (c == ESC_ESC_BYTE) c = ESC_BYTE;
        esc_pend = 1'b0;
      end else if (c == ESC_BYTE) begin
        esc_pend = 1'b1;
        return;
      end
      // capacity above the frame size acts as the frame size
      cap = (32'(capacity) > MAX_FRAME_DEF) ? MAX_FRAME_DEF : 32'(capacity);
      if (count >= cap) return;
      if (count == 0) first_b = c;
      else if (count == 1) second_b = c;
      penult_b = last_b;
      last_b   = c;
      r.kind   = KIND_DATA;
      r.data   = c;
      r.index  = count[5:0];
      expected_words.push_back(r);
      count++;
    endfunction

    function int waiting();
      return expected_words.size();
    endfunction

    task report(string msg);
      if (fails < 20) $display("%0t: mismatch on word %0d: %s", $time, seen, msg);
      fails++;
    endtask

    // Compare one accepted result word with the oldest expectation
    task check_result(result_t got);
      result_t exp;
      seen++;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind %0b", got.kind));
        return;
      end
      exp = expected_words.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("kind %0b, expected %0b", got.kind, exp.kind));
      if (got.data !== exp.data)
        report($sformatf("data_byte %02h, expected %02h", got.data, exp.data));
      if (got.index !== exp.index)
        report($sformatf("byte_index %0d, expected %0d", got.index, exp.index));
      if (got.length !== exp.length)
        report($sformatf("frame_length %0d, expected %0d", got.length, exp.length));
      if (got.is_reply !== exp.is_reply)
        report($sformatf("is_reply %0b, expected %0b", got.is_reply, exp.is_reply));
      if (got.success !== exp.success)
        report($sformatf("success %0b, expected %0b", got.success, exp.success));
      if (got.reason !== exp.reason)
        report($sformatf("reason_code %02h, expected %02h", got.reason, exp.reason));
      if (exp.kind == KIND_DATA) n_data++;
      else n_summary++;
      if (exp.is_reply) n_reply++;
      if (exp.success) n_success++;
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       result_kind_o;
  logic [7:0] data_byte_o;
  logic [5:0] byte_index_o;
  logic [6:0] frame_length_o;
  logic       is_reply_o;
  logic       success_o;
  logic [7:0] reason_code_o;

  reply_frame_tracker tracker;
  logic [7:0]  line_q[$];
  int          burst_left;
  int unsigned bytes_sent;

  slip_reply_deframer_checker i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .is_reply_o     (is_reply_o),
    .success_o      (success_o),
    .reason_code_o  (reason_code_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Raw byte sender: bursts of words with random gaps in between
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk_i);
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_line();
    while (line_q.size() > 0) send_byte(line_q.pop_front());
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Let every result drain, then allow for words that give no result
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (tracker.waiting() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Mostly ordinary data, with a good share of SLIP special bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return END_BYTE;
      1: return ESC_BYTE;
      2: return ESC_END_BYTE;
      3: return ESC_ESC_BYTE;
      4: return 8'h00;
      5: return 8'hFF;
      6: return REPLY_DIR;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_encoded(logic [7:0] b);
    if (b == END_BYTE) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(ESC_END_BYTE);
    end else if (b == ESC_BYTE) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(ESC_ESC_BYTE);
    end else begin
      line_q.push_back(b);
    end
  endfunction

  // One framed message; often shaped like a reply, sometimes cut short
  function automatic void build_frame();
    int         len;
    logic [7:0] b;
    bit         shaped;
    bit         zero_pen;
    line_q.push_back(END_BYTE);
    case ($urandom_range(0, 9))
      7, 8:    len = $urandom_range(13, 40);
      9:       len = $urandom_range(60, 72);
      default: len = $urandom_range(0, 12);
    endcase
    shaped   = 1'($urandom_range(0, 1));
    zero_pen = 1'($urandom_range(0, 1));
    for (int k = 0; k < len; k++) begin
      b = pick_byte();
      if (shaped && k == 0) b = REPLY_DIR;
      if (shaped && k == 1 && $urandom_range(0, 3) != 0) b = tracker.command;
      if (zero_pen && k == len - 2) b = 8'h00;
      // escape of an ordinary byte passes it through
      if ($urandom_range(0, 19) == 0 && b != END_BYTE && b != ESC_BYTE) begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(b);
      end else begin
        push_encoded(b);
      end
      // broken sequence: escape cut off by a delimiter
      if ($urandom_range(0, 59) == 0) begin
        line_q.push_back(ESC_BYTE);
        break;
      end
    end
    line_q.push_back(END_BYTE);
  endfunction

  function automatic void build_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) line_q.push_back(pick_byte());
  endfunction

  // Result receiver: stall pattern switches between several modes
  initial begin : receiver
    int mode;
    int left;
    int hold;
    out_ready_i = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: out_ready_i = 1'b1;
        1: out_ready_i = 1'($urandom_range(0, 1));
        2: out_ready_i = (left % 4 == 0);
        default: begin
          if (hold > 0) begin
            out_ready_i = 1'b0;
            hold--;
          end else begin
            out_ready_i = 1'b1;
            hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
          end
        end
      endcase
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin : sample_results
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind     = result_kind_o;
      got.data     = data_byte_o;
      got.index    = byte_index_o;
      got.length   = frame_length_o;
      got.is_reply = is_reply_o;
      got.success  = success_o;
      got.reason   = reason_code_o;
      tracker.check_result(got);
    end
  end

  // Run limit
  initial begin
    #(12 * 500_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] cap_set[PHASES];
    logic [7:0] cmd_set[PHASES];
    logic [7:0] min_set[PHASES];
    int unsigned phase_start;
    int unsigned target;
    tracker     = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CAPACITY;
    cfg_data_i  = 8'h00;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    burst_left  = 0;
    bytes_sent  = 0;
    // capacity, command, minimum length per phase; zero capacity never closes
    cap_set = '{8'hFF, 8'd1, 8'd0, 8'd64, 8'd3, 8'd65, 8'($urandom_range(1, 64))};
    cmd_set = '{8'h00, 8'hFF, 8'h08, 8'h08, 8'($urandom), END_BYTE, 8'($urandom)};
    min_set = '{8'd0, 8'hFF, 8'd10, 8'd10, 8'd2, 8'd64, 8'($urandom_range(0, 64))};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at reset settings
    // noise before any delimiter
    line_q = '{8'h00, 8'hFF, ESC_BYTE, ESC_END_BYTE};
    // opening delimiter, then an empty frame
    line_q.push_back(END_BYTE);
    line_q.push_back(END_BYTE);
    // full reply: both escapes, escaped ordinary byte, zero status
    line_q.push_back(REPLY_DIR);
    line_q.push_back(COMMAND_RST);
    line_q.push_back(ESC_BYTE);
    line_q.push_back(ESC_END_BYTE);
    line_q.push_back(ESC_BYTE);
    line_q.push_back(ESC_ESC_BYTE);
    line_q.push_back(ESC_BYTE);
    line_q.push_back(8'h41);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    line_q.push_back(8'h55);
    line_q.push_back(8'h00);
    line_q.push_back(8'h2A);
    line_q.push_back(END_BYTE);
    // one-byte frame
    line_q.push_back(END_BYTE);
    line_q.push_back(8'h5A);
    line_q.push_back(END_BYTE);
    // delimiter right after an escape closes the frame
    line_q.push_back(END_BYTE);
    line_q.push_back(8'h33);
    line_q.push_back(ESC_BYTE);
    line_q.push_back(END_BYTE);
    send_line();

    // Random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_CAPACITY, cap_set[p]);
      write_reg(CFG_COMMAND, cmd_set[p]);
      write_reg(CFG_MIN_LEN, min_set[p]);
      if (p == 3) write_reg(CFG_SPARE, 8'($urandom));
      target      = (cap_set[p] == 8'd0) ? EMPTY_PHASE_BYTES : PHASE_BYTES;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < target) begin
        if ($urandom_range(0, 9) == 0) build_noise();
        else build_frame();
        send_line();
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.waiting() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d raw bytes over %0d settings; checked %0d words.",
             bytes_sent, PHASES + 1, tracker.seen);
    $display("Decoded bytes %0d, frame summaries %0d (replies %0d, success %0d).",
             tracker.n_data, tracker.n_summary, tracker.n_reply, tracker.n_success);
    if (tracker.fails == 0 && tracker.waiting() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/slip_rdc_pkg.sv
rtl/core/slip_rdc_cfg.sv
rtl/core/slip_rdc_decode.sv
rtl/core/slip_reply_deframer_checker.sv
sim/tb_top.sv
